// ===== hw/rtl/tlbfl_pkg.sv =====
// Shared constants, types and codes of the translation lookaside buffer.
package tlbfl_pkg;

    localparam int MAX_ENTRIES   = 32;
    localparam int IDX_W         = $clog2(MAX_ENTRIES);
    localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
    localparam int RANK_W        = 5;
    localparam int RANK_MAX      = 31;
    localparam int PAGE_LOG2_MAX = 16;

    localparam int PID_W    = 16;
    localparam int ADDR_W   = 32;
    localparam int FRAME_W  = 16;
    localparam int OFFSET_W = 16;
    localparam int SLOT_W   = 5;
    localparam int EIU_W    = 6;
    localparam int PSL2_W   = 5;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_ADDR_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_POLICY         = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAGE_SIZE_LOG2 = 2'd2;

    typedef enum logic {
        POL_FIFO = 1'b0,
        POL_LRU  = 1'b1
    } t_policy;

    typedef enum logic {
        REQ_TRANSLATE = 1'b0,
        REQ_FILL      = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [ADDR_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic              set_valid;
        logic [IDX_W-1:0]  slot;
        logic [RANK_W:0]   old_rank;
    } t_touch;

endpackage

// ===== hw/rtl/tlbfl_entry_ram.sv =====
// Entry store holding process id, page and frame of each buffer entry.
module tlbfl_entry_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [tlbfl_pkg::IDX_W-1:0]   i_waddr,
    input  tlbfl_pkg::t_entry             i_wdata,
    input  logic [tlbfl_pkg::IDX_W-1:0]   i_raddr,
    output tlbfl_pkg::t_entry             o_rdata
);

    tlbfl_pkg::t_entry r_mem [tlbfl_pkg::MAX_ENTRIES];
    tlbfl_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tlbfl_age.sv =====
// Valid bits and age ranks of the entries, with the most recently used update.
module tlbfl_age (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tlbfl_pkg::CNT_W-1:0]   i_n,
    input  tlbfl_pkg::t_touch             i_touch,
    input  logic [tlbfl_pkg::IDX_W-1:0]   i_rd_idx,
    output logic                          o_rd_valid,
    output logic [tlbfl_pkg::RANK_W-1:0]  o_rd_rank
);

    logic [tlbfl_pkg::MAX_ENTRIES-1:0] r_valid;
    logic [tlbfl_pkg::MAX_ENTRIES-1:0] n_valid;
    logic [tlbfl_pkg::RANK_W-1:0]      r_rank [tlbfl_pkg::MAX_ENTRIES];
    logic [tlbfl_pkg::RANK_W-1:0]      n_rank [tlbfl_pkg::MAX_ENTRIES];

    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < tlbfl_pkg::MAX_ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (i_touch.en) begin
                if (tlbfl_pkg::IDX_W'(i) == i_touch.slot) begin
                    n_rank[i] = '0;
                    if (i_touch.set_valid) begin
                        n_valid[i] = 1'b1;
                    end
                end else if ((tlbfl_pkg::CNT_W'(i) < i_n) && r_valid[i]
                             && ({1'b0, r_rank[i]} < i_touch.old_rank)
                             && (r_rank[i] < tlbfl_pkg::RANK_W'(tlbfl_pkg::RANK_MAX))) begin
                    n_rank[i] = r_rank[i] + tlbfl_pkg::RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < tlbfl_pkg::MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            for (int i = 0; i < tlbfl_pkg::MAX_ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    assign o_rd_valid = r_valid[i_rd_idx];
    assign o_rd_rank  = r_rank[i_rd_idx];

endmodule

// ===== hw/rtl/tlb_translate_fifo_lru_core.sv =====
// Top level of the translation lookaside buffer with FIFO or LRU replacement.
//
// Requests arrive as words on the s_axis channel: a translate lookup or a fill
// after a miss, tagged by process id. Each request gives exactly one result
// word on the m_axis channel with hit, frame, page number, page offset, slot
// and eviction flag. Registers are to be written through the plain write port
// only while the block is idle; the block itself does not enforce this.
// A request is handled by one compare unit that walks the entries in use, one
// entry per cycle, from a synchronous entry store. A disabled buffer skips the
// walk. The input is ready only between requests, so a new request is taken
// only after the result of the last one has been written to the output register.
// The result sits in an output register; if the receiver stalls, the block
// finishes the walk and waits with its updates until that register is free.
// Reset clears all valid bits, age ranks and the FIFO pointer at once and
// restores the registers to 32 entries, FIFO policy and 16 byte pages.
module tlb_translate_fifo_lru_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tlbfl_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [tlbfl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: pid, logical_address, fill_frame.
    input  logic [63:0]                          s_axis_tdata,
    // Fields from bit 0: req_type.
    input  logic [0:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: hit, frame, page_number, page_offset, slot_index,
    // evicted, one zero pad bit.
    output logic [71:0]                          m_axis_tdata
);

    localparam int IW = tlbfl_pkg::IDX_W;
    localparam int CW = tlbfl_pkg::CNT_W;
    localparam int RW = tlbfl_pkg::RANK_W;

    tlbfl_pkg::t_state   r_state, n_state;
    logic [tlbfl_pkg::EIU_W-1:0]    r_eiu;
    tlbfl_pkg::t_policy             r_policy;
    logic [tlbfl_pkg::PSL2_W-1:0]   r_psl2;

    logic                           r_fill, n_fill;
    logic [tlbfl_pkg::PID_W-1:0]    r_pid, n_pid;
    logic [tlbfl_pkg::ADDR_W-1:0]   r_page, n_page;
    logic [tlbfl_pkg::OFFSET_W-1:0] r_offset, n_offset;
    logic [tlbfl_pkg::FRAME_W-1:0]  r_fframe, n_fframe;
    logic [CW-1:0]                  r_n, n_n;
    logic [CW-1:0]                  r_issue, n_issue;
    logic                           r_cmp_en, n_cmp_en;
    logic [IW-1:0]                  r_cmp_idx, n_cmp_idx;
    logic                           r_match_f, n_match_f;
    logic [IW-1:0]                  r_match_idx, n_match_idx;
    logic [RW-1:0]                  r_match_rank, n_match_rank;
    logic [tlbfl_pkg::FRAME_W-1:0]  r_match_frame, n_match_frame;
    logic                           r_free_f, n_free_f;
    logic [IW-1:0]                  r_free_idx, n_free_idx;
    logic [RW-1:0]                  r_best, n_best;
    logic [IW-1:0]                  r_best_idx, n_best_idx;
    logic [IW-1:0]                  r_fifo_slot, n_fifo_slot;
    logic [RW-1:0]                  r_fifo_rank, n_fifo_rank;
    logic [IW-1:0]                  r_fifo_next, n_fifo_next;
    logic                           r_m_valid, n_m_valid;
    logic [71:0]                    r_m_data, n_m_data;

    logic [tlbfl_pkg::PSL2_W-1:0]   sh;
    logic [CW-1:0]                  n_active;
    logic [tlbfl_pkg::ADDR_W-1:0]   in_addr;
    logic [tlbfl_pkg::OFFSET_W-1:0] off_mask;
    logic                           ram_we;
    logic [IW-1:0]                  ram_waddr;
    tlbfl_pkg::t_entry              ram_wdata;
    tlbfl_pkg::t_entry              ram_rdata;
    tlbfl_pkg::t_touch              touch;
    logic                           rd_valid;
    logic [RW-1:0]                  rd_rank;
    logic                           cmp_match;
    logic                           res_hit;
    logic                           res_evicted;
    logic [tlbfl_pkg::FRAME_W-1:0]  res_frame;
    logic [IW-1:0]                  res_slot;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eiu    <= tlbfl_pkg::EIU_W'(32);
            r_policy <= tlbfl_pkg::POL_FIFO;
            r_psl2   <= tlbfl_pkg::PSL2_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tlbfl_pkg::CFG_ENTRIES_IN_USE: begin
                    r_eiu <= i_cfg_wdata[tlbfl_pkg::EIU_W-1:0];
                end
                tlbfl_pkg::CFG_POLICY: begin
                    r_policy <= tlbfl_pkg::t_policy'(i_cfg_wdata[0]);
                end
                tlbfl_pkg::CFG_PAGE_SIZE_LOG2: begin
                    r_psl2 <= i_cfg_wdata[tlbfl_pkg::PSL2_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign sh = (r_psl2 > tlbfl_pkg::PSL2_W'(tlbfl_pkg::PAGE_LOG2_MAX))
              ? tlbfl_pkg::PSL2_W'(tlbfl_pkg::PAGE_LOG2_MAX) : r_psl2;
    assign n_active = (r_eiu > tlbfl_pkg::EIU_W'(tlbfl_pkg::MAX_ENTRIES))
                    ? CW'(tlbfl_pkg::MAX_ENTRIES) : CW'(r_eiu);
    assign in_addr  = s_axis_tdata[47:16];
    assign off_mask = tlbfl_pkg::OFFSET_W'((32'd1 << sh) - 32'd1);

    assign cmp_match = rd_valid && (ram_rdata.pid == r_pid) && (ram_rdata.page == r_page);

    tlbfl_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_issue[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    tlbfl_age u_age (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_n        (r_n),
        .i_touch    (touch),
        .i_rd_idx   (r_cmp_idx),
        .o_rd_valid (rd_valid),
        .o_rd_rank  (rd_rank)
    );

    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_pid         = r_pid;
        n_page        = r_page;
        n_offset      = r_offset;
        n_fframe      = r_fframe;
        n_n           = r_n;
        n_issue       = r_issue;
        n_cmp_en      = r_cmp_en;
        n_cmp_idx     = r_cmp_idx;
        n_match_f     = r_match_f;
        n_match_idx   = r_match_idx;
        n_match_rank  = r_match_rank;
        n_match_frame = r_match_frame;
        n_free_f      = r_free_f;
        n_free_idx    = r_free_idx;
        n_best        = r_best;
        n_best_idx    = r_best_idx;
        n_fifo_slot   = r_fifo_slot;
        n_fifo_rank   = r_fifo_rank;
        n_fifo_next   = r_fifo_next;
        n_m_valid     = r_m_valid && !m_axis_tready;
        n_m_data      = r_m_data;
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '{pid: r_pid, page: r_page, frame: r_fframe};
        touch         = '0;
        res_hit       = 1'b0;
        res_evicted   = 1'b0;
        res_frame     = '0;
        res_slot      = '0;

        case (r_state)
            tlbfl_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_fill      = (s_axis_tuser[0] == tlbfl_pkg::REQ_FILL);
                    n_pid       = s_axis_tdata[15:0];
                    n_page      = in_addr >> sh;
                    n_offset    = in_addr[tlbfl_pkg::OFFSET_W-1:0] & off_mask;
                    n_fframe    = s_axis_tdata[63:48];
                    n_n         = n_active;
                    n_issue     = '0;
                    n_cmp_en    = 1'b0;
                    n_match_f   = 1'b0;
                    n_free_f    = 1'b0;
                    n_best      = '0;
                    n_best_idx  = '0;
                    n_fifo_rank = '0;
                    n_fifo_slot = (CW'(r_fifo_next) < n_active) ? r_fifo_next : '0;
                    n_state     = (n_active == '0) ? tlbfl_pkg::ST_UPD : tlbfl_pkg::ST_SCAN;
                end
            end
            tlbfl_pkg::ST_SCAN: begin
                n_cmp_en = (r_issue < r_n);
                if (r_issue < r_n) begin
                    n_cmp_idx = r_issue[IW-1:0];
                    n_issue   = r_issue + CW'(1);
                end
                if (r_cmp_en) begin
                    if (cmp_match && !r_match_f) begin
                        n_match_f     = 1'b1;
                        n_match_idx   = r_cmp_idx;
                        n_match_rank  = rd_rank;
                        n_match_frame = ram_rdata.frame;
                    end
                    if (!rd_valid && !r_free_f) begin
                        n_free_f   = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                    if (rd_rank > r_best) begin
                        n_best     = rd_rank;
                        n_best_idx = r_cmp_idx;
                    end
                    if (r_cmp_idx == r_fifo_slot) begin
                        n_fifo_rank = rd_rank;
                    end
                    if (CW'(r_cmp_idx) + CW'(1) == r_n) begin
                        n_state = tlbfl_pkg::ST_UPD;
                    end
                end
            end
            tlbfl_pkg::ST_UPD: begin
                if (!r_m_valid || m_axis_tready) begin
                    if (r_n != '0) begin
                        if (!r_fill) begin
                            if (r_match_f) begin
                                res_hit        = 1'b1;
                                res_frame      = r_match_frame;
                                res_slot       = r_match_idx;
                                touch.en       = 1'b1;
                                touch.slot     = r_match_idx;
                                touch.old_rank = {1'b0, r_match_rank};
                            end
                        end else begin
                            res_frame = r_fframe;
                            ram_we    = 1'b1;
                            touch.en  = 1'b1;
                            if (r_match_f) begin
                                res_slot       = r_match_idx;
                                touch.old_rank = {1'b0, r_match_rank};
                            end else if (r_free_f) begin
                                res_slot       = r_free_idx;
                                touch.old_rank = (RW+1)'(tlbfl_pkg::RANK_MAX + 1);
                            end else begin
                                res_evicted = 1'b1;
                                if (r_policy == tlbfl_pkg::POL_LRU) begin
                                    res_slot       = r_best_idx;
                                    touch.old_rank = {1'b0, r_best};
                                end else begin
                                    res_slot       = r_fifo_slot;
                                    touch.old_rank = {1'b0, r_fifo_rank};
                                    n_fifo_next    = (CW'(r_fifo_slot) + CW'(1) < r_n)
                                                   ? r_fifo_slot + IW'(1) : '0;
                                end
                            end
                            touch.set_valid = !r_match_f;
                            touch.slot      = res_slot;
                            ram_waddr       = res_slot;
                        end
                    end else if (r_fill) begin
                        res_frame = r_fframe;
                    end
                    n_m_valid = 1'b1;
                    n_m_data  = {1'b0, res_evicted, tlbfl_pkg::SLOT_W'(res_slot), r_offset,
                                 r_page, res_frame, res_hit};
                    n_state   = tlbfl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tlbfl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlbfl_pkg::ST_IDLE;
            r_cmp_en    <= 1'b0;
            r_fifo_next <= '0;
            r_m_valid   <= 1'b0;
            r_issue     <= '0;
            r_n         <= '0;
        end else begin
            r_state     <= n_state;
            r_cmp_en    <= n_cmp_en;
            r_fifo_next <= n_fifo_next;
            r_m_valid   <= n_m_valid;
            r_issue     <= n_issue;
            r_n         <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill        <= n_fill;
        r_pid         <= n_pid;
        r_page        <= n_page;
        r_offset      <= n_offset;
        r_fframe      <= n_fframe;
        r_cmp_idx     <= n_cmp_idx;
        r_match_f     <= n_match_f;
        r_match_idx   <= n_match_idx;
        r_match_rank  <= n_match_rank;
        r_match_frame <= n_match_frame;
        r_free_f      <= n_free_f;
        r_free_idx    <= n_free_idx;
        r_best        <= n_best;
        r_best_idx    <= n_best_idx;
        r_fifo_slot   <= n_fifo_slot;
        r_fifo_rank   <= n_fifo_rank;
        r_m_data      <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

`ifndef SYNTH
    a_touch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        touch.en |-> (CW'(touch.slot) < r_n))
        else $error("Entry update outside the entries in use.");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state != tlbfl_pkg::ST_IDLE))
        else $error("Accepted word did not start a lookup.");

    a_hit_not_evicted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !(r_m_data[0] && r_m_data[70]))
        else $error("Result marks both a hit and an eviction.");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlbfl_pkg::ST_UPD && n_state == tlbfl_pkg::ST_IDLE) |=> r_m_valid)
        else $error("Finished request produced no result word.");
`endif

endmodule
